>>> rtl/pid_controller_anti_windup_defines.svh
// ----------------------------------------------------------------------------
// pid_controller_anti_windup_defines
// Assertion macros shared by the rtl.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_ANTI_WINDUP_DEFINES_SVH
`define PID_CONTROLLER_ANTI_WINDUP_DEFINES_SVH

// same-cycle implication, reset masked
`define PIDAW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define PIDAW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// Types, constants and helpers of the fixed-point pid controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pidaw_pkg;

    localparam int VALUE_WIDTH    = 32;
    localparam int FRACTION_BITS  = 16;
    localparam int DT_BITS        = 16;
    localparam int INTEGRAL_WIDTH = VALUE_WIDTH + DT_BITS;
    localparam int MAG_W          = VALUE_WIDTH + INTEGRAL_WIDTH;
    localparam int CFG_INDEX_W    = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P  = 3'd0,
        REG_GAIN_I  = 3'd1,
        REG_GAIN_D  = 3'd2,
        REG_UPPER   = 3'd3,
        REG_LOWER   = 3'd4,
        REG_GUARD   = 3'd5
    } cfg_reg_t;

    localparam logic REQ_COMPUTE = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    typedef struct packed {
        logic                            req_type;
        logic signed [VALUE_WIDTH-1:0]   target_value;
        logic signed [VALUE_WIDTH-1:0]   measured_value;
        logic        [DT_BITS-1:0]       time_step;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0]   drive_value;
        logic                            was_clamped;
    } rsp_t;

    typedef struct packed {
        logic start;
        logic wide;
    } mul_cmd_t;

    typedef struct packed {
        logic                          busy;
        logic signed [VALUE_WIDTH-1:0] value;
    } unit_sts_t;

    // signed value from magnitude and sign, truncated toward zero, saturated
    function automatic logic [VALUE_WIDTH-1:0] sat_from_mag(
        input logic [MAG_W-1:0] m,
        input logic             neg
    );
        logic hi_zero;
        logic [VALUE_WIDTH-1:0] res;
        hi_zero = (m[MAG_W-1:VALUE_WIDTH] == '0);
        if (!neg)
        begin
            if (!hi_zero || m[VALUE_WIDTH-1])
                res = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            else
                res = m[VALUE_WIDTH-1:0];
        end
        else
        begin
            if (!hi_zero || (m[VALUE_WIDTH-1] && (m[VALUE_WIDTH-2:0] != '0)))
                res = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            else
                res = '0 - m[VALUE_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pidaw_req_if.sv
// ----------------------------------------------------------------------------
// pidaw_req_if
// Request channel: valid, ready and one request beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidaw_req_if;
    logic              valid;
    logic              ready;
    pidaw_pkg::req_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/pidaw_rsp_if.sv
// ----------------------------------------------------------------------------
// pidaw_rsp_if
// Result channel: valid, ready and one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidaw_rsp_if;
    logic              valid;
    logic              ready;
    pidaw_pkg::rsp_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/pidaw_mul.sv
// ----------------------------------------------------------------------------
// pidaw_mul
// Serial shift-add multiplier, one gain bit per cycle, with shift and
// saturation of the product to the value width.
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_mul (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire pidaw_pkg::mul_cmd_t                          cmd,
    input  wire logic signed [pidaw_pkg::VALUE_WIDTH-1:0]     mul_a,
    input  wire logic signed [pidaw_pkg::INTEGRAL_WIDTH-1:0]  mul_b,
    output pidaw_pkg::unit_sts_t                              sts
);

    localparam int A_W   = pidaw_pkg::VALUE_WIDTH;
    localparam int B_W   = pidaw_pkg::INTEGRAL_WIDTH;
    localparam int P_W   = pidaw_pkg::MAG_W;
    localparam int CNT_W = $clog2(A_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [A_W-1:0]   mplier_reg;
    logic [B_W-1:0]   mcand_reg;
    logic [P_W-1:0]   acc_reg;
    logic             neg_reg;
    logic             wide_reg;
    logic [A_W-1:0]   value_reg;

    logic [A_W-1:0]   mag_a;
    logic [B_W-1:0]   mag_b;
    logic [B_W:0]     sum;
    logic [P_W-1:0]   acc_next;
    logic [P_W-1:0]   shifted;

    always_comb
    begin
        mag_a    = mul_a[A_W-1] ? ('0 - A_W'(mul_a)) : A_W'(mul_a);
        mag_b    = mul_b[B_W-1] ? ('0 - B_W'(mul_b)) : B_W'(mul_b);
        sum      = {1'b0, acc_reg[P_W-1:A_W]} + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);
        acc_next = {sum, acc_reg[A_W-1:1]};
        shifted  = wide_reg ? (acc_reg >> (pidaw_pkg::FRACTION_BITS + pidaw_pkg::DT_BITS))
                            : (acc_reg >> pidaw_pkg::FRACTION_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg   <= 1'b1;
            cnt_reg    <= '0;
            mplier_reg <= mag_a;
            mcand_reg  <= mag_b;
            acc_reg    <= '0;
            neg_reg    <= mul_a[A_W-1] ^ mul_b[B_W-1];
            wide_reg   <= cmd.wide;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(A_W))
            begin
                value_reg <= pidaw_pkg::sat_from_mag(shifted, neg_reg);
                busy_reg  <= 1'b0;
            end
            else
            begin
                acc_reg    <= acc_next;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + 1'b1;
            end
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.value = value_reg;

endmodule

`default_nettype wire

>>> rtl/pidaw_div.sv
// ----------------------------------------------------------------------------
// pidaw_div
// Restoring divider of the error change by the time step, one quotient bit
// per cycle, saturated to the value width.
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_div (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        start,
    input  wire logic signed [pidaw_pkg::VALUE_WIDTH:0]      diff,
    input  wire logic        [pidaw_pkg::DT_BITS-1:0]        dt,
    output pidaw_pkg::unit_sts_t                             sts
);

    localparam int D_W   = pidaw_pkg::VALUE_WIDTH + 1;
    localparam int T_W   = pidaw_pkg::DT_BITS;
    localparam int NUM_W = D_W + T_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                           busy_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [NUM_W-1:0]               num_reg;
    logic [T_W-1:0]                 rem_reg;
    logic [T_W-1:0]                 dt_reg;
    logic                           neg_reg;
    logic [pidaw_pkg::VALUE_WIDTH-1:0] value_reg;

    logic [D_W-1:0] mag_diff;
    logic [T_W:0]   trial;
    logic           ge;
    logic [T_W:0]   rem_sub;

    always_comb
    begin
        mag_diff = diff[D_W-1] ? ('0 - D_W'(diff)) : D_W'(diff);
        trial    = {rem_reg, num_reg[NUM_W-1]};
        ge       = (trial >= {1'b0, dt_reg});
        rem_sub  = trial - {1'b0, dt_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            num_reg  <= {mag_diff, {T_W{1'b0}}};
            rem_reg  <= '0;
            dt_reg   <= dt;
            neg_reg  <= diff[D_W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(NUM_W))
            begin
                value_reg <= pidaw_pkg::sat_from_mag(pidaw_pkg::MAG_W'(num_reg), neg_reg);
                busy_reg  <= 1'b0;
            end
            else
            begin
                rem_reg <= ge ? rem_sub[T_W-1:0] : trial[T_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.value = value_reg;

endmodule

`default_nettype wire

>>> rtl/pid_controller_anti_windup.sv
// ----------------------------------------------------------------------------
// pid_controller_anti_windup
// Fixed-point pid controller with conditional-integration anti-windup.
// ----------------------------------------------------------------------------
// req carries one beat per control step: restart, or setpoint, measurement
// and time step (Q16.16, Q16.16, Q0.16). rsp returns the clamped drive and a
// clamp flag for each compute step; a restart returns nothing.
// Gains, limits and the guard enable are written through cfg_wr_en,
// cfg_index and cfg_data; the user must write them only while no step is in
// flight, as the block itself does not enforce it. A compute step runs the
// setup states S_ERR, S_PROD and S_TENT, then the 49-step restoring divider
// for the derivative (run beside the 32-step serial multipliers for the
// proportional and integral terms, and skipped for a zero time step), one
// more 32-step multiply by the derivative gain, and a final sum and clamp.
// A restart is handled in the idle state. One step is in flight at a time.
// The result sits in an output register: req is taken again as soon as the
// result is written there, even while rsp is stalled; a second result waits
// in the final stage until the first is taken.
// Reset clears the controller state, sets the first-step mark, zeroes the
// gains, opens the limits to full scale and turns the guard off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pid_controller_anti_windup_defines.svh"

module pid_controller_anti_windup (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    pidaw_req_if.sink                                   req,
    pidaw_rsp_if.source                                 rsp,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [pidaw_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [pidaw_pkg::VALUE_WIDTH-1:0]      cfg_data
);

    localparam int VW = pidaw_pkg::VALUE_WIDTH;
    localparam int IW = pidaw_pkg::INTEGRAL_WIDTH;
    localparam int TW = pidaw_pkg::DT_BITS;
    localparam int SW = VW + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_PROD,
        S_TENT,
        S_KI,
        S_WAIT,
        S_DMUL,
        S_DWAIT,
        S_SUM
    } state_t;

    state_t state_reg;

    logic signed [VW-1:0] kp_reg, ki_reg, kd_reg, lim_hi_reg, lim_lo_reg;
    logic                 guard_reg;

    logic signed [VW-1:0] last_err_reg;
    logic signed [IW-1:0] integral_reg;
    logic                 first_reg;

    logic signed [VW-1:0] sp_reg, meas_reg, err_reg, p_reg;
    logic        [TW-1:0] dt_reg;
    logic signed [VW:0]   diff_reg;
    logic signed [IW-1:0] prodi_reg, tent_reg;

    logic                 rsp_valid_reg;
    pidaw_pkg::rsp_t      rsp_reg;

    pidaw_pkg::mul_cmd_t  cmd_a, cmd_b, cmd_c;
    pidaw_pkg::unit_sts_t sts_a, sts_b, sts_c, sts_div;
    logic                 div_start;
    logic signed [VW-1:0] mul_a_gain;
    logic signed [IW-1:0] mul_a_val;
    logic signed [VW-1:0] deriv;

    logic signed [VW:0]   err_diff;
    logic signed [VW-1:0] err_sat;
    logic signed [VW+TW:0] prodi_full;
    logic signed [IW:0]   tent_sum;
    logic signed [IW-1:0] tent_sat;
    logic signed [SW-1:0] tent_out, out_sum, hi_x, lo_x;
    logic                 upd;
    logic signed [VW-1:0] drive;
    logic                 clamped;
    logic                 slot_free;

    pidaw_mul u_mul_a (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_a),
        .mul_a (mul_a_gain),
        .mul_b (mul_a_val),
        .sts   (sts_a)
    );

    pidaw_mul u_mul_b (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_b),
        .mul_a (ki_reg),
        .mul_b (tent_reg),
        .sts   (sts_b)
    );

    pidaw_mul u_mul_c (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_c),
        .mul_a (ki_reg),
        .mul_b (integral_reg),
        .sts   (sts_c)
    );

    pidaw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .diff  (diff_reg),
        .dt    (dt_reg),
        .sts   (sts_div)
    );

    always_comb
    begin
        cmd_a.start = (state_reg == S_PROD) || (state_reg == S_DMUL);
        cmd_a.wide  = 1'b0;
        cmd_b.start = (state_reg == S_KI);
        cmd_b.wide  = 1'b1;
        cmd_c.start = (state_reg == S_PROD);
        cmd_c.wide  = 1'b1;
        div_start   = (state_reg == S_TENT) && (dt_reg != '0);

        deriv      = (dt_reg == '0) ? '0 : sts_div.value;
        mul_a_gain = (state_reg == S_DMUL) ? kd_reg : kp_reg;
        mul_a_val  = (state_reg == S_DMUL) ? IW'(deriv) : IW'(err_reg);

        err_diff = (VW+1)'(sp_reg) - (VW+1)'(meas_reg);
        if (err_diff > $signed({2'b00, {(VW-1){1'b1}}}))
            err_sat = {1'b0, {(VW-1){1'b1}}};
        else if (err_diff < $signed({2'b11, {(VW-1){1'b0}}}))
            err_sat = {1'b1, {(VW-1){1'b0}}};
        else
            err_sat = err_diff[VW-1:0];

        prodi_full = (VW+TW+1)'(err_reg) * $signed({1'b0, dt_reg});

        tent_sum = (IW+1)'(integral_reg) + (IW+1)'(prodi_reg);
        if (tent_sum[IW] != tent_sum[IW-1])
            tent_sat = tent_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        else
            tent_sat = tent_sum[IW-1:0];

        hi_x     = SW'(lim_hi_reg);
        lo_x     = SW'(lim_lo_reg);
        tent_out = SW'(p_reg) + SW'(sts_a.value) + SW'(sts_b.value);
        upd      = !first_reg && (!guard_reg || ((tent_out < hi_x) && (tent_out >= lo_x)));
        out_sum  = SW'(p_reg) + SW'(sts_a.value) + (upd ? SW'(sts_b.value) : SW'(sts_c.value));
        if (out_sum > hi_x)
        begin
            drive   = lim_hi_reg;
            clamped = 1'b1;
        end
        else if (out_sum < lo_x)
        begin
            drive   = lim_lo_reg;
            clamped = 1'b1;
        end
        else
        begin
            drive   = out_sum[VW-1:0];
            clamped = 1'b0;
        end

        slot_free = !rsp_valid_reg || rsp.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            lim_hi_reg <= {1'b0, {(VW-1){1'b1}}};
            lim_lo_reg <= {1'b1, {(VW-1){1'b0}}};
            guard_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (pidaw_pkg::cfg_reg_t'(cfg_index))
                pidaw_pkg::REG_GAIN_P: kp_reg     <= cfg_data;
                pidaw_pkg::REG_GAIN_I: ki_reg     <= cfg_data;
                pidaw_pkg::REG_GAIN_D: kd_reg     <= cfg_data;
                pidaw_pkg::REG_UPPER:  lim_hi_reg <= cfg_data;
                pidaw_pkg::REG_LOWER:  lim_lo_reg <= cfg_data;
                pidaw_pkg::REG_GUARD:  guard_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_err_reg  <= '0;
            integral_reg  <= '0;
            first_reg     <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && (state_reg != S_SUM))
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        if (req.payload.req_type == pidaw_pkg::REQ_RESTART)
                        begin
                            last_err_reg <= '0;
                            integral_reg <= '0;
                            first_reg    <= 1'b1;
                        end
                        else
                        begin
                            sp_reg    <= req.payload.target_value;
                            meas_reg  <= req.payload.measured_value;
                            dt_reg    <= req.payload.time_step;
                            state_reg <= S_ERR;
                        end
                    end
                end
                S_ERR:
                begin
                    err_reg   <= err_sat;
                    state_reg <= S_PROD;
                end
                S_PROD:
                begin
                    diff_reg  <= (VW+1)'(err_reg) - (VW+1)'(last_err_reg);
                    prodi_reg <= prodi_full[IW-1:0];
                    state_reg <= S_TENT;
                end
                S_TENT:
                begin
                    tent_reg  <= tent_sat;
                    state_reg <= S_KI;
                end
                S_KI:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!sts_a.busy && !sts_b.busy && !sts_c.busy && !sts_div.busy)
                    begin
                        p_reg     <= sts_a.value;
                        state_reg <= S_DMUL;
                    end
                end
                S_DMUL:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (!sts_a.busy)
                        state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (slot_free)
                    begin
                        if (upd)
                            integral_reg <= tent_reg;
                        first_reg           <= 1'b0;
                        last_err_reg        <= err_reg;
                        rsp_reg.drive_value <= drive;
                        rsp_reg.was_clamped <= clamped;
                        rsp_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    `PIDAW_ASSERT_SAME(a_idle_units_quiet, req.ready, !sts_a.busy && !sts_b.busy && !sts_c.busy && !sts_div.busy, "arith unit busy while idle")
    `PIDAW_ASSERT_NEXT(a_restart_clears, req.valid && req.ready && (req.payload.req_type == pidaw_pkg::REQ_RESTART), first_reg && (integral_reg == '0) && (last_err_reg == '0), "restart did not clear state")
    `PIDAW_ASSERT_SAME(a_unclamped_in_range, rsp_valid_reg && !rsp_reg.was_clamped, (rsp_reg.drive_value <= lim_hi_reg) && (rsp_reg.drive_value >= lim_lo_reg), "unclamped drive outside limits")

endmodule

`default_nettype wire
